FILE: hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared codes and types for the minimum tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    // Operation codes carried in the input tuser field. Code 3 acts as a peek.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    // Status codes carried in the output tuser field.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 9;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;

    // One-hot sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } t_state;

    // What the fill cycle has to finish for an accepted pop.
    typedef struct packed {
        logic load_top;
        logic load_min;
    } t_pend;

endpackage

FILE: hw/rtl/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// A LIFO stack of signed 32-bit values that also reports its current minimum.
// Each item on the input stream is a push, a pop or a peek, and each gives
// exactly one result item with the returned value, the minimum, the count
// and a status. The values live in one RAM and the running minima in a
// second RAM; the top of each is cached in a register so that a push or a
// peek needs no read. An item is accepted in S_IDLE and finished in S_FILL:
// in the accept cycle the counts, the cached tops and the RAM writes are
// settled and the entries just below the tops are read, and in S_FILL the
// registered RAM data replaces the cached tops after a pop and the result
// is loaded into the output register. The output register lets the next
// item be accepted while a result still waits; the fill cycle stalls only
// while the output register is full and not being taken. A pop or peek on
// an empty stack reports underflow with zero data and minimum, and a push
// onto a full stack is refused with overflow status. Opcode 3 behaves as a
// peek. No clearing pass is needed after reset: only entries below the
// counts are read.
// ----------------------------------------------------------------------------
module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input items.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [31:0] data_in
    input  logic [1:0]             i_s_axis_tuser,  // [1:0] opcode
    // Result items.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // [31:0] data_out,
                                                    // [63:32] min_out,
                                                    // [72:64] count_out,
                                                    // [79:73] zero
    output logic [1:0]             o_m_axis_tuser   // [1:0] status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Sequencer, counts and cached tops.
    t_state             r_state, n_state;
    logic [CW-1:0]      r_vcnt, n_vcnt;
    logic [CW-1:0]      r_mcnt, n_mcnt;
    logic [DATA_W-1:0]  r_top, n_top;
    logic [DATA_W-1:0]  r_top_min, n_top_min;
    t_pend              r_pend, n_pend;

    // Result being assembled and the output register.
    logic [DATA_W-1:0]  r_res_data, n_res_data;
    logic [1:0]         r_res_status, n_res_status;
    logic               r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic [1:0]         r_out_tuser, n_out_tuser;

    // RAM ports.
    logic               val_wr_en, min_wr_en, rd_en;
    logic [AW-1:0]      val_wr_addr, min_wr_addr, val_rd_addr, min_rd_addr;
    logic [DATA_W-1:0]  in_data, val_rd_data, min_rd_data;
    logic [CW-1:0]      vcnt_m2, mcnt_m2;

    logic               in_accept, fill_load;
    logic               is_empty, is_full, push_min;
    logic [DATA_W-1:0]  fill_min;
    logic [COUNT_OUT_W-1:0] count_ext;

    assign in_data   = i_s_axis_tdata[DATA_W-1:0];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign fill_load = (r_state == S_FILL) && (!r_out_valid || i_m_axis_tready);

    assign is_empty = (r_vcnt == '0);
    assign is_full  = (r_vcnt >= CW'(STACK_DEPTH));
    // The minimum stack takes a push that ties or undercuts its top.
    assign push_min = (r_mcnt == '0) || ($signed(in_data) <= $signed(r_top_min));

    // A pop needs the entries just below the current tops.
    assign vcnt_m2     = r_vcnt - CW'(2);
    assign mcnt_m2     = r_mcnt - CW'(2);
    assign val_rd_addr = vcnt_m2[AW-1:0];
    assign min_rd_addr = mcnt_m2[AW-1:0];
    assign rd_en       = in_accept;

    assign val_wr_addr = r_vcnt[AW-1:0];
    assign min_wr_addr = r_mcnt[AW-1:0];
    assign val_wr_en   = in_accept && (i_s_axis_tuser == OP_PUSH) && !is_full;
    assign min_wr_en   = val_wr_en && push_min;

    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (val_wr_en),
        .i_wr_addr (val_wr_addr),
        .i_wr_data (in_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (val_rd_addr),
        .o_rd_data (val_rd_data)
    );

    mts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_min_ram (
        .i_clk     (i_clk),
        .i_wr_en   (min_wr_en),
        .i_wr_addr (min_wr_addr),
        .i_wr_data (in_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (min_rd_addr),
        .o_rd_data (min_rd_data)
    );

    // Minimum after the item: the RAM data replaces the cached top when the
    // pop also removed the current minimum.
    assign fill_min  = r_pend.load_min ? min_rd_data : r_top_min;
    assign count_ext = COUNT_OUT_W'(r_vcnt);

    always_comb begin
        n_state      = r_state;
        n_vcnt       = r_vcnt;
        n_mcnt       = r_mcnt;
        n_top        = r_top;
        n_top_min    = r_top_min;
        n_pend       = r_pend;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_tdata  = r_out_tdata;
        n_out_tuser  = r_out_tuser;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state       = S_FILL;
                    n_pend        = '0;
                    n_res_status  = ST_OK;
                    n_res_data    = is_empty ? '0 : r_top;
                    case (i_s_axis_tuser)
                        OP_PUSH: begin
                            if (is_full) begin
                                n_res_status = ST_OVER;
                            end else begin
                                n_vcnt     = r_vcnt + CW'(1);
                                n_top      = in_data;
                                n_res_data = in_data;
                                if (push_min) begin
                                    n_mcnt    = r_mcnt + CW'(1);
                                    n_top_min = in_data;
                                end
                            end
                        end
                        OP_POP: begin
                            if (is_empty) begin
                                n_res_status = ST_UNDER;
                            end else begin
                                n_vcnt          = r_vcnt - CW'(1);
                                n_pend.load_top = 1'b1;
                                if (r_mcnt != '0 && r_top == r_top_min) begin
                                    n_mcnt          = r_mcnt - CW'(1);
                                    n_pend.load_min = 1'b1;
                                end
                            end
                        end
                        default: begin
                            if (is_empty) begin
                                n_res_status = ST_UNDER;
                            end
                        end
                    endcase
                end
            end
            S_FILL: begin
                if (fill_load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_tuser = r_res_status;
                    n_out_tdata = {
                        (OUT_TDATA_W - 2 * DATA_W - COUNT_OUT_W)'(0),
                        count_ext,
                        (r_vcnt == '0) ? {DATA_W{1'b0}} : fill_min,
                        r_res_data
                    };
                    if (r_pend.load_top) begin
                        n_top = val_rd_data;
                    end
                    n_top_min = fill_min;
                    n_pend    = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcnt      <= '0;
            r_mcnt      <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcnt      <= n_vcnt;
            r_mcnt      <= n_mcnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_top_min    <= n_top_min;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_tdata  <= n_out_tdata;
        r_out_tuser  <= n_out_tuser;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

    // The minimum stack never holds more entries than the value stack.
    a_mcnt_le_vcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcnt <= r_vcnt)
        else $error("minimum count exceeds value count");

    // A non-empty stack always has a minimum entry.
    a_min_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vcnt != '0) |-> (r_mcnt != '0))
        else $error("non-empty stack without a minimum entry");

    // The value count stays within the stack depth.
    a_vcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt <= CW'(STACK_DEPTH))
        else $error("value count beyond stack depth");

    // An accepted item is always followed by its fill cycle.
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_FILL))
        else $error("accepted item without a fill cycle");

    // An overflow result only comes from a full stack.
    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fill_load && r_res_status == ST_OVER) |-> (r_vcnt == CW'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

endmodule

FILE: hw/rtl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
